// File: rtl/palette_colour_resolver_macros.svh
// Assertion macros for the palette colour resolver checker.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef PALETTE_COLOUR_RESOLVER_MACROS_SVH
`define PALETTE_COLOUR_RESOLVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold later than the antecedent, not in the same cycle.
`define PCR_ASSERT_LAT2(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: rtl/pcr_pkg.sv
// Shared constants for the palette colour resolver.
// Used by the top level, its port checker and the testbench files; no dependencies.
package pcr_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int IDX_W       = $clog2(PAL_ENTRIES);
  localparam int CNT_W       = $clog2(PAL_ENTRIES + 1);
  localparam int COLOUR_W    = 31;
  localparam int TDATA_W     = 32;

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Pack {alpha[7:1], red, green, blue} from the input stream word.
  function automatic logic [COLOUR_W-1:0] pack_colour(input logic [TDATA_W-1:0] data);
    pack_colour = {data[31:25], data[7:0], data[15:8], data[23:16]};
  endfunction

endpackage

// File: rtl/palette_colour_resolver.sv
// Palette colour resolver: packs an RGBA request and maps it to a palette index.
// Input stream: s_axis_* carries one request item; output stream m_axis_* one result item.
// Configuration: cfg_we_i/cfg_wdata_i write the true-colour mode bit at a clock edge.
// In true-colour mode the packed 31-bit colour word is returned as it is.
// In indexed mode a zero colour returns index 0; otherwise the next free palette
// entry (filled in index order from 1) takes the colour and its index is returned.
// Once all entries are taken, the block scans entries 1 to PAL_ENTRIES-1 with one
// subtract/compare unit and returns the nearest index, the lower index on a tie.
// With no scan needed, an accepted item goes through ST_DONE to the output register;
// with a full palette the scan lies between, paced by the one memory read per cycle.
// s_axis_tready is high only while the sequencer is idle; one item is in work at a time.
// A finished result sits in an output register, so a new item is taken while it
// waits; if the receiver stalls, the next result holds until the register frees.
// Reset (rst_ni low, asynchronous) clears the mode bit and sets the fill count to 1,
// which empties the palette at once; no clearing pass is needed.
module palette_colour_resolver
  import pcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_wdata_i,    // true_colour_mode
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TDATA_W-1:0]  s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata    // colour_or_index[30:0], zero[31]
);

  logic [COLOUR_W-1:0] palette_mem [PAL_ENTRIES];

  logic [1:0]          state_q, state_d;
  logic                mode_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [COLOUR_W-1:0] colour_q;
  logic [COLOUR_W-1:0] res_q;
  logic [COLOUR_W-1:0] out_q;
  logic                out_vld_q;
  logic [IDX_W-1:0]    ptr_q;
  logic                issue_q;
  logic                v1_q, v2_q;
  logic [IDX_W-1:0]    idx1_q, idx2_q;
  logic [COLOUR_W-1:0] rd_data_q;
  logic [COLOUR_W-1:0] dist_q;
  logic [COLOUR_W-1:0] best_dist_q;
  logic [IDX_W-1:0]    best_idx_q;

  logic [COLOUR_W-1:0] packed_w;
  logic [COLOUR_W-1:0] abs_diff_w;
  logic                accept_w;
  logic                out_free_w;
  logic                full_w;
  logic                wr_en_w;
  logic                rd_en_w;
  logic                scan_end_w;

  assign packed_w      = pack_colour(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_w      = s_axis_tvalid && s_axis_tready;
  assign out_free_w    = !out_vld_q || m_axis_tready;
  assign full_w        = (cnt_q == CNT_W'(PAL_ENTRIES));
  assign wr_en_w       = accept_w && !mode_q && (packed_w != '0) && !full_w;
  assign rd_en_w       = (state_q == ST_SCAN) && issue_q;
  assign scan_end_w    = (state_q == ST_SCAN) && !issue_q && !v1_q && !v2_q;
  assign abs_diff_w    = (colour_q > rd_data_q) ? (colour_q - rd_data_q)
                                                : (rd_data_q - colour_q);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(TDATA_W-COLOUR_W){1'b0}}, out_q};

  // Palette store: one write port at accept, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (wr_en_w) begin
      palette_mem[cnt_q[IDX_W-1:0]] <= packed_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_w) begin
      rd_data_q <= palette_mem[ptr_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          state_d = (mode_q || (packed_w == '0) || !full_w) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end_w) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_w) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= 1'b0;
      cnt_q     <= CNT_W'(1);
      out_vld_q <= 1'b0;
      issue_q   <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i[0];
      end
      if (wr_en_w) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // Stop issuing after the last entry
      if (rd_en_w && (ptr_q == IDX_W'(PAL_ENTRIES - 1))) begin
        issue_q <= 1'b0;
      end else if (accept_w && (state_d == ST_SCAN)) begin
        issue_q <= 1'b1;
      end
      v1_q <= rd_en_w;
      v2_q <= v1_q;
      if ((state_q == ST_DONE) && out_free_w) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath: address pointer, distance stage, running minimum
  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      colour_q    <= packed_w;
      ptr_q       <= IDX_W'(1);
      best_dist_q <= '1;
      best_idx_q  <= '0;
      if (mode_q) begin
        res_q <= packed_w;
      end else if (packed_w == '0) begin
        res_q <= '0;
      end else begin
        res_q <= {{(COLOUR_W-CNT_W){1'b0}}, cnt_q};
      end
    end
    if (rd_en_w) begin
      ptr_q  <= ptr_q + IDX_W'(1);
      idx1_q <= ptr_q;
    end
    if (v1_q) begin
      dist_q <= abs_diff_w;
      idx2_q <= idx1_q;
    end
    // Strict less-than keeps the lower index on a tie
    if (v2_q && (dist_q < best_dist_q)) begin
      best_dist_q <= dist_q;
      best_idx_q  <= idx2_q;
    end
    if (scan_end_w) begin
      res_q <= {{(COLOUR_W-IDX_W){1'b0}}, best_idx_q};
    end
    if ((state_q == ST_DONE) && out_free_w) begin
      out_q <= res_q;
    end
  end

endmodule

// File: rtl/pcr_checker.sv
// Port-level checker for the palette colour resolver, bound to the top level.
// Depends on pcr_pkg and palette_colour_resolver_macros.svh.
`include "palette_colour_resolver_macros.svh"

module pcr_checker
  import pcr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [0:0]         cfg_wdata_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [TDATA_W-1:0] s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  logic                mode_q;
  logic [COLOUR_W-1:0] packed_w;
  logic                in_acc_w;

  // Track the mode bit from the configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i[0];
    end
  end

  assign packed_w = pack_colour(s_axis_tdata);
  assign in_acc_w = s_axis_tvalid && s_axis_tready;

  `PCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result item dropped while stalled")
  `PCR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result item changed while stalled")
  `PCR_ASSERT_NOW(a_index_range, clk_i, rst_ni, m_axis_tvalid && !mode_q, m_axis_tdata[TDATA_W-1:IDX_W] == '0, "palette index out of range")
  `PCR_ASSERT_LAT2(a_true_colour, clk_i, rst_ni, in_acc_w && mode_q && !m_axis_tvalid, m_axis_tvalid && (m_axis_tdata[COLOUR_W-1:0] == $past(packed_w, 2)), "true-colour result wrong or late")

endmodule

bind palette_colour_resolver pcr_checker u_pcr_checker (.*);

// File: tb/pcr_result_checker.sv
// Result checker for the palette colour resolver: watches the config port and both streams,
// predicts every result and compares it with what the block returns.
// Depends on pcr_pkg for widths and the palette size.
`timescale 1ns / 1ps

module pcr_result_checker
  import pcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_wdata_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,   // colour_or_index[30:0], zero[31]
  output int                 mismatches_o,
  output int                 pending_o
);

  logic                true_colour;
  logic [COLOUR_W-1:0] palette [PAL_ENTRIES];
  logic [COLOUR_W-1:0] expected_results [$];
  int                  fail_count;

  // Pack the request and either return it or resolve it against the palette copy.
  function automatic logic [COLOUR_W-1:0] resolve_request(input logic [TDATA_W-1:0] req);
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic [COLOUR_W-1:0] word;
    logic [COLOUR_W-1:0] delta;
    logic [31:0]         best_dist;
    int unsigned         best_idx;
    red   = req[7:0];
    green = req[15:8];
    blue  = req[23:16];
    alpha = req[31:24];
    word  = {alpha[7:1], red, green, blue};
    if (true_colour) return word;
    if (word == '0) return '0;
    best_dist = '1;
    best_idx  = 0;
    for (int unsigned i = 1; i < PAL_ENTRIES; i++) begin
      // First empty slot takes the colour.
      if (palette[i] == '0) begin
        palette[i] = word;
        return COLOUR_W'(i);
      end
      delta = (word > palette[i]) ? word - palette[i] : palette[i] - word;
      // Strict compare keeps the lower index on a tie.
      if ({1'b0, delta} < best_dist) begin
        best_dist = {1'b0, delta};
        best_idx  = i;
      end
    end
    return COLOUR_W'(best_idx);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [COLOUR_W-1:0] want;
    if (!rst_ni) begin
      true_colour = 1'b0;
      for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
      expected_results.delete();
      fail_count = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) true_colour = cfg_wdata_i[0];
      // Pop before push: a result at this edge can never belong to an item taken at it.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %h arrived with nothing expected", $time, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== {1'b0, want}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: colour_or_index expected %h, got %h", $time,
                       {1'b0, want}, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(resolve_request(s_axis_tdata));
      mismatches_o <= fail_count;
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: tb/tb_palette_colour_resolver.sv
// Testbench top for palette_colour_resolver: clock, reset, config writes and stream traffic.
// Checking is done by pcr_result_checker; this module only drives items and gives the verdict.
// Depends on pcr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_palette_colour_resolver;
  import pcr_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_wdata_i = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  int                 mismatches;
  int                 pending;

  // Shared between sender and receiver.
  bit                 no_gaps = 1'b0;
  int unsigned        rx_hold_cycles = 0;

  // Sender bookkeeping.
  bit                 tx_live = 1'b0;
  int unsigned        tx_gap = 0;
  bit                 mode_tc = 1'b0;
  logic [COLOUR_W-1:0] stored_colours [$];
  int unsigned        items_sent = 0;
  int unsigned        tc_items = 0;
  int unsigned        idx_items = 0;
  int unsigned        mode_writes = 0;

  palette_colour_resolver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pcr_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stall per item, plus a long hold when asked for.
  initial begin : rx_side
    int unsigned gap;
    bit          rx_live;
    rx_live = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap != 0) begin
        if (rx_live) begin
          m_axis_tready <= 1'b0;
          rx_live = 1'b0;
        end
        repeat (gap) @(posedge clk_i);
      end
      if (!rx_live) begin
        m_axis_tready <= 1'b1;
        rx_live = 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_rgba(input logic [7:0] red, green, blue, alpha);
    logic [COLOUR_W-1:0] word;
    word = {alpha[7:1], red, green, blue};
    repeat (tx_gap) @(posedge clk_i);
    s_axis_tdata <= {alpha, blue, green, red};
    if (!tx_live) begin
      s_axis_tvalid <= 1'b1;
      tx_live = 1'b1;
    end
    do @(posedge clk_i); while (!s_axis_tready);
    // Keep valid up when the next item follows at once.
    tx_gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (tx_gap != 0) begin
      s_axis_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    items_sent++;
    if (mode_tc) tc_items++;
    else idx_items++;
    if (!mode_tc && word != '0 && stored_colours.size() < PAL_ENTRIES - 1)
      stored_colours.push_back(word);
  endtask

  task automatic send_word(input logic [COLOUR_W-1:0] word);
    send_rgba(word[23:16], word[15:8], word[7:0], {word[30:24], 1'($urandom_range(0, 1))});
  endtask

  // Drop valid and hold until every result is back.
  task automatic wait_idle();
    if (tx_live) begin
      s_axis_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_mode(input bit tc);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_tc = tc;
    mode_writes++;
  endtask

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_item();
    int unsigned         kind;
    longint              word;
    logic [COLOUR_W-1:0] p;
    logic [COLOUR_W-1:0] q;
    kind = $urandom_range(0, 99);
    p = '0;
    q = '0;
    if (stored_colours.size() == 0) begin
      if (kind >= 35 && kind < 80) kind = 0;
    end else begin
      p = stored_colours[$urandom_range(0, stored_colours.size() - 1)];
      q = stored_colours[$urandom_range(0, stored_colours.size() - 1)];
    end
    if (kind < 35) begin
      send_rgba(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (kind < 55) begin
      // Land close to a stored colour.
      word = longint'(p) + longint'($urandom_range(0, 600)) - 300;
      if (word < 1) word = 1;
      if (word > 64'h7FFF_FFFF) word = 64'h7FFF_FFFF;
      send_word(word[COLOUR_W-1:0]);
    end else if (kind < 70) begin
      // Midpoint of two stored colours: equal distances test the tie rule.
      word = (longint'(p) + longint'(q)) / 2;
      send_word(word[COLOUR_W-1:0]);
    end else if (kind < 80) begin
      send_word(p);
    end else if (kind < 85) begin
      send_rgba(8'h00, 8'h00, 8'h00, 8'($urandom_range(0, 1)));
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0:       send_word(31'h7FFF_FFFF);
        1:       send_word(31'h0000_0001);
        2:       send_word(31'h4000_0000);
        default: send_word(31'h00FF_FFFF);
      endcase
    end else begin
      send_rgba(corner_byte(), corner_byte(), corner_byte(), corner_byte());
    end
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 63) == 0) wait_idle();
      random_item();
    end
  endtask

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Indexed mode corners: zero colour, alpha that halves to zero, channel extremes,
    // a repeated colour taking its own entry.
    write_mode(1'b0);
    send_rgba(8'h00, 8'h00, 8'h00, 8'h00);
    send_rgba(8'h00, 8'h00, 8'h00, 8'h01);
    send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_rgba(8'hFF, 8'h00, 8'h00, 8'h00);
    send_rgba(8'h00, 8'hFF, 8'h00, 8'h00);
    send_rgba(8'h00, 8'h00, 8'hFF, 8'h00);
    send_rgba(8'h00, 8'h00, 8'h00, 8'hFF);
    send_rgba(8'h00, 8'h00, 8'h00, 8'h02);
    send_rgba(8'h00, 8'h00, 8'h01, 8'h00);
    send_rgba(8'hAA, 8'h55, 8'hAA, 8'h55);

    // True-colour corners.
    write_mode(1'b1);
    send_rgba(8'h00, 8'h00, 8'h00, 8'h00);
    send_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_rgba(8'h00, 8'h00, 8'h00, 8'h01);
    send_rgba(8'h00, 8'h00, 8'h00, 8'hFE);
    send_rgba(8'h80, 8'h01, 8'h7F, 8'h80);
    send_rgba(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_rgba(8'h01, 8'h00, 8'h00, 8'h00);

    // Fill the palette, pausing once until the block has drained.
    write_mode(1'b0);
    while (stored_colours.size() < PAL_ENTRIES - 1) begin
      if (!paused && stored_colours.size() >= PAL_ENTRIES / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      random_item();
    end

    // Fast true-colour traffic with a long receiver hold so the input backs up.
    write_mode(1'b1);
    no_gaps = 1'b1;
    rx_hold_cycles = 80;
    for (int n = 0; n < 40; n++) random_item();
    run_random(160);

    // Full palette: nearest-match search.
    write_mode(1'b0);
    run_random(600);
    write_mode(1'b1);
    write_mode(1'b1);
    run_random(150);
    write_mode(1'b0);
    if (items_sent < 1500) run_random(1500 - items_sent);

    wait_idle();
    repeat (PAL_ENTRIES + 8) @(posedge clk_i);
    $display("covered %0d requests: %0d true-colour, %0d indexed, over %0d mode writes",
             items_sent, tc_items, idx_items, mode_writes);
    $display("palette filled to %0d entries before nearest-match traffic",
             stored_colours.size());
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: palette_colour_resolver.f
+incdir+rtl
rtl/pcr_pkg.sv
rtl/palette_colour_resolver.sv
rtl/pcr_checker.sv
tb/pcr_result_checker.sv
tb/tb_palette_colour_resolver.sv
